/* hw/rtl/lsfp_pkg.sv */
// Package: constants, types and shared definitions for the laser status frame parser.
package lsfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CAP_DEPTH   = 17;
    localparam int unsigned CAP_IW      = $clog2(CAP_DEPTH);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] SYNC_FIRST   = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND  = 8'hAA;
    localparam logic [BYTE_W-1:0] CMD_LASER_ON = 8'hC1;
    localparam logic [BYTE_W-1:0] CMD_IDENTITY = 8'hD1;
    localparam logic [BYTE_W-1:0] CMD_IGNORED  = 8'hD2;
    localparam logic [BYTE_W-1:0] CMD_STATUS   = 8'hD3;

    typedef enum logic [1:0] {
        KIND_LASER_ON = 2'd0,
        KIND_IDENTITY = 2'd1,
        KIND_STATUS   = 2'd2
    } t_kind;

    typedef logic [CAP_DEPTH-1:0][BYTE_W-1:0] t_capture;

    typedef struct packed {
        t_kind    kind;
        t_capture payload;
    } t_frame;

endpackage

/* hw/rtl/lsfp_if.sv */
// Interfaces: received byte channel and parsed frame result channel.
interface lsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lsfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic        laser_on;
    logic [31:0] serial_high;
    logic [39:0] serial_low;
    logic [7:0]  work_status;
    logic [7:0]  alarm_bits;
    logic [15:0] temperature;
    logic [15:0] drive_current;
    logic [15:0] output_power;
    logic [15:0] set_power;

    modport source (
        output valid, output frame_kind, output laser_on, output serial_high,
        output serial_low, output work_status, output alarm_bits, output temperature,
        output drive_current, output output_power, output set_power, input ready
    );
    modport sink (
        input valid, input frame_kind, input laser_on, input serial_high,
        input serial_low, input work_status, input alarm_bits, input temperature,
        input drive_current, input output_power, input set_power, output ready
    );
endinterface

/* hw/rtl/laser_status_frame_parser_unit.sv */
// Top level: laser status frame parser, front end, frame queue and result stage.
// Throughput: one received byte per cycle while the frame queue has room.
// A result passes from the queue, written at the transfer of the second checksum byte,
// into the result register, which loads once that register is empty or its result is taken.
// Input stalls only while the two-entry frame queue is full.
// Reset (synchronous, active low): parser hunts the first sync byte, queue and result empty.
module laser_status_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsfp_in_if.sink     i_in,
    lsfp_out_if.source  o_out
);

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    lsfp_pkg::t_frame w_front_frame;
    lsfp_pkg::t_frame w_back_frame;

    lsfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_frame      (w_front_frame)
    );

    lsfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_front_frame),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_frame (w_back_frame)
    );

    lsfp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_frame (w_back_frame),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

/* hw/rtl/lsfp_front.sv */
// Sync hunt, header decode and payload capture; one byte per cycle when ready.
module lsfp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lsfp_in_if.sink         i_in,
    input  logic            i_queue_full,
    output logic            o_push,
    output lsfp_pkg::t_frame o_frame
);

    typedef enum logic [6:0] {
        PH_HUNT0 = 7'b0000001,
        PH_HUNT1 = 7'b0000010,
        PH_CMD   = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_CK0   = 7'b0100000,
        PH_CK1   = 7'b1000000
    } t_phase;

    t_phase                            r_phase, n_phase;
    logic [lsfp_pkg::BYTE_W-1:0]       r_length, n_length;
    logic [lsfp_pkg::BYTE_W-1:0]       r_count, n_count;
    logic                              r_kind_ok, n_kind_ok;
    lsfp_pkg::t_kind                   r_kind, n_kind;
    lsfp_pkg::t_capture                r_cap, n_cap;
    logic                              w_take;
    logic [lsfp_pkg::BYTE_W-1:0]       w_b;
    logic [lsfp_pkg::BYTE_W-1:0]       w_count_inc;

    assign i_in.ready  = !i_queue_full;
    assign w_take      = i_in.valid && i_in.ready;
    assign w_b         = i_in.rx_byte;
    assign w_count_inc = r_count + 8'd1;

    assign o_push          = w_take && (r_phase == PH_CK1) && r_kind_ok;
    assign o_frame.kind    = r_kind;
    assign o_frame.payload = r_cap;

    always_comb begin
        n_phase   = r_phase;
        n_length  = r_length;
        n_count   = r_count;
        n_kind_ok = r_kind_ok;
        n_kind    = r_kind;
        n_cap     = r_cap;
        if (w_take) begin
            unique case (r_phase)
                PH_HUNT0: begin
                    if (w_b == lsfp_pkg::SYNC_FIRST) n_phase = PH_HUNT1;
                end
                PH_HUNT1: begin
                    if (w_b == lsfp_pkg::SYNC_SECOND) n_phase = PH_CMD;
                    else if (w_b != lsfp_pkg::SYNC_FIRST) n_phase = PH_HUNT0;
                end
                PH_CMD: begin
                    n_cap   = '0;
                    n_count = '0;
                    n_phase = PH_LEN;
                    unique case (w_b)
                        lsfp_pkg::CMD_LASER_ON: begin
                            n_kind_ok = 1'b1;
                            n_kind    = lsfp_pkg::KIND_LASER_ON;
                        end
                        lsfp_pkg::CMD_IDENTITY: begin
                            n_kind_ok = 1'b1;
                            n_kind    = lsfp_pkg::KIND_IDENTITY;
                        end
                        lsfp_pkg::CMD_STATUS: begin
                            n_kind_ok = 1'b1;
                            n_kind    = lsfp_pkg::KIND_STATUS;
                        end
                        lsfp_pkg::CMD_IGNORED: begin
                            n_kind_ok = 1'b0;
                            n_kind    = lsfp_pkg::KIND_LASER_ON;
                        end
                        default: begin
                            n_kind_ok = 1'b0;
                            n_kind    = lsfp_pkg::KIND_LASER_ON;
                        end
                    endcase
                end
                PH_LEN: begin
                    n_length = w_b;
                    n_count  = '0;
                    n_phase  = (w_b == '0) ? PH_CK0 : PH_DATA;
                end
                PH_DATA: begin
                    if (r_count < lsfp_pkg::BYTE_W'(lsfp_pkg::CAP_DEPTH)) begin
                        n_cap[r_count[lsfp_pkg::CAP_IW-1:0]] = w_b;
                    end
                    n_count = w_count_inc;
                    if (w_count_inc >= r_length) n_phase = PH_CK0;
                end
                PH_CK0: n_phase = PH_CK1;
                PH_CK1: n_phase = PH_HUNT0;
                default: n_phase = PH_HUNT0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT0;
            r_length  <= '0;
            r_count   <= '0;
            r_kind_ok <= 1'b0;
            r_kind    <= lsfp_pkg::KIND_LASER_ON;
        end else begin
            r_phase   <= n_phase;
            r_length  <= n_length;
            r_count   <= n_count;
            r_kind_ok <= n_kind_ok;
            r_kind    <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap <= n_cap;
    end

endmodule

/* hw/rtl/lsfp_queue.sv */
// Short frame queue between the front end and the result formatter.
module lsfp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lsfp_pkg::t_frame i_frame,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output lsfp_pkg::t_frame o_frame
);

    lsfp_pkg::t_frame                r_mem [lsfp_pkg::QUEUE_DEPTH];
    logic [lsfp_pkg::QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [lsfp_pkg::QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [lsfp_pkg::QUEUE_CW-1:0]   r_fill, n_fill;
    logic                            w_push, w_pop;

    assign o_full  = (r_fill == lsfp_pkg::QUEUE_CW'(lsfp_pkg::QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == lsfp_pkg::QUEUE_AW'(lsfp_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == lsfp_pkg::QUEUE_AW'(lsfp_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) n_fill = r_fill + 1'b1;
        else if (w_pop && !w_push) n_fill = r_fill - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_frame;
    end

endmodule

/* hw/rtl/lsfp_back.sv */
// Back end: field extraction per frame kind into the registered result stage.
module lsfp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  lsfp_pkg::t_frame i_frame,
    output logic             o_pop,
    lsfp_out_if.source       o_out
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic        r_laser_on;
    logic [31:0] r_serial_high;
    logic [39:0] r_serial_low;
    logic [7:0]  r_work_status;
    logic [7:0]  r_alarm_bits;
    logic [15:0] r_temperature;
    logic [15:0] r_drive_current;
    logic [15:0] r_output_power;
    logic [15:0] r_set_power;

    logic        n_laser_on;
    logic [31:0] n_serial_high;
    logic [39:0] n_serial_low;
    logic [7:0]  n_work_status;
    logic [7:0]  n_alarm_bits;
    logic [15:0] n_temperature;
    logic [15:0] n_drive_current;
    logic [15:0] n_output_power;
    logic [15:0] n_set_power;

    lsfp_pkg::t_capture w_p;

    assign w_p   = i_frame.payload;
    assign o_pop = !i_empty && (!r_valid || o_out.ready);

    // payload index is frame offset minus four
    always_comb begin
        n_laser_on      = 1'b0;
        n_serial_high   = '0;
        n_serial_low    = '0;
        n_work_status   = '0;
        n_alarm_bits    = '0;
        n_temperature   = '0;
        n_drive_current = '0;
        n_output_power  = '0;
        n_set_power     = '0;
        unique case (i_frame.kind)
            lsfp_pkg::KIND_LASER_ON: begin
                n_laser_on = (w_p[0] == 8'd1);
            end
            lsfp_pkg::KIND_IDENTITY: begin
                n_serial_high = {w_p[8], w_p[9], w_p[10], w_p[11]};
                n_serial_low  = {w_p[12], w_p[13], w_p[14], w_p[15], w_p[16]};
            end
            lsfp_pkg::KIND_STATUS: begin
                n_work_status   = w_p[0];
                n_alarm_bits    = w_p[1];
                n_temperature   = {w_p[3], w_p[2]};
                n_drive_current = {w_p[5], w_p[4]};
                n_output_power  = {w_p[7], w_p[6]};
                n_set_power     = {w_p[9], w_p[8]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind          <= i_frame.kind;
            r_laser_on      <= n_laser_on;
            r_serial_high   <= n_serial_high;
            r_serial_low    <= n_serial_low;
            r_work_status   <= n_work_status;
            r_alarm_bits    <= n_alarm_bits;
            r_temperature   <= n_temperature;
            r_drive_current <= n_drive_current;
            r_output_power  <= n_output_power;
            r_set_power     <= n_set_power;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.frame_kind    = r_kind;
    assign o_out.laser_on      = r_laser_on;
    assign o_out.serial_high   = r_serial_high;
    assign o_out.serial_low    = r_serial_low;
    assign o_out.work_status   = r_work_status;
    assign o_out.alarm_bits    = r_alarm_bits;
    assign o_out.temperature   = r_temperature;
    assign o_out.drive_current = r_drive_current;
    assign o_out.output_power  = r_output_power;
    assign o_out.set_power     = r_set_power;

endmodule

/* sim/laser_status_frame_parser_unit_tb.sv */
// Testbench for the laser status frame parser: random byte streams, scoreboard, handshake stalls.
`timescale 1ns / 1ps

module laser_status_frame_parser_unit_tb;

    localparam int RX_TARGET   = 850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [6:0] {
        HUNT_FIRST  = 7'b0000001,
        HUNT_SECOND = 7'b0000010,
        TAKE_CMD    = 7'b0000100,
        TAKE_LEN    = 7'b0001000,
        TAKE_DATA   = 7'b0010000,
        SKIP_CK0    = 7'b0100000,
        SKIP_CK1    = 7'b1000000
    } t_parse_phase;

    typedef struct packed {
        lsfp_pkg::t_kind kind;
        logic        laser_on;
        logic [31:0] serial_high;
        logic [39:0] serial_low;
        logic [7:0]  work_status;
        logic [7:0]  alarm_bits;
        logic [15:0] temperature;
        logic [15:0] drive_current;
        logic [15:0] output_power;
        logic [15:0] set_power;
    } t_frame_result;

    typedef struct {
        logic [7:0] data;
        bit         drain;
        bit         squeeze;
        bit         quiet;
    } t_rx_slot;

    logic i_clk;
    logic i_rst_n;

    lsfp_in_if  rx_ch ();
    lsfp_out_if res_ch ();

    laser_status_frame_parser_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_ch),
        .o_out   (res_ch)
    );

    t_rx_slot      rx_pending[$];
    t_frame_result frames_expected[$];

    t_parse_phase  phase;
    logic [7:0]    frame_cmd;
    logic [7:0]    frame_len;
    logic [7:0]    data_count;
    logic [7:0]    capture[lsfp_pkg::CAP_DEPTH];

    int  mismatches = 0;
    int  cycles = 0;
    int  rx_items;
    bit  gen_quiet;
    bit  gen_squeeze;
    int  send_gap;
    int  recv_gap;
    int  hold_cnt;
    bit  stall_go;
    bit  rx_calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void parse_rx_byte(input logic [7:0] b);
        t_frame_result r;
        r = '0;
        case (phase)
            HUNT_FIRST: begin
                if (b == lsfp_pkg::SYNC_FIRST) phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                if (b == lsfp_pkg::SYNC_SECOND) phase = TAKE_CMD;
                else if (b != lsfp_pkg::SYNC_FIRST) phase = HUNT_FIRST;
            end
            TAKE_CMD: begin
                frame_cmd = b;
                foreach (capture[i]) capture[i] = '0;
                data_count = '0;
                phase = TAKE_LEN;
            end
            TAKE_LEN: begin
                frame_len = b;
                data_count = '0;
                phase = (b == 8'd0) ? SKIP_CK0 : TAKE_DATA;
            end
            TAKE_DATA: begin
                if (data_count < lsfp_pkg::CAP_DEPTH)
                    capture[data_count[lsfp_pkg::CAP_IW-1:0]] = b;
                data_count = data_count + 8'd1;
                if (data_count >= frame_len) phase = SKIP_CK0;
            end
            SKIP_CK0: phase = SKIP_CK1;
            default: begin
                phase = HUNT_FIRST;
                if (frame_cmd == lsfp_pkg::CMD_LASER_ON) begin
                    r.kind     = lsfp_pkg::KIND_LASER_ON;
                    r.laser_on = (capture[0] == 8'd1);
                    frames_expected.push_back(r);
                end else if (frame_cmd == lsfp_pkg::CMD_IDENTITY) begin
                    r.kind        = lsfp_pkg::KIND_IDENTITY;
                    r.serial_high = {capture[8], capture[9], capture[10], capture[11]};
                    r.serial_low  = {capture[12], capture[13], capture[14], capture[15],
                                     capture[16]};
                    frames_expected.push_back(r);
                end else if (frame_cmd == lsfp_pkg::CMD_STATUS) begin
                    r.kind          = lsfp_pkg::KIND_STATUS;
                    r.work_status   = capture[0];
                    r.alarm_bits    = capture[1];
                    r.temperature   = {capture[3], capture[2]};
                    r.drive_current = {capture[5], capture[4]};
                    r.output_power  = {capture[7], capture[6]};
                    r.set_power     = {capture[9], capture[8]};
                    frames_expected.push_back(r);
                end
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    task automatic check_frame(input t_frame_result got);
        t_frame_result want;
        if (frames_expected.size() == 0) begin
            flag_mismatch("unexpected frame, kind", got.kind, 0);
        end else begin
            want = frames_expected.pop_front();
            if (got.kind !== want.kind)
                flag_mismatch("frame_kind", got.kind, want.kind);
            if (got.laser_on !== want.laser_on)
                flag_mismatch("laser_on", got.laser_on, want.laser_on);
            if (got.serial_high !== want.serial_high)
                flag_mismatch("serial_high", got.serial_high, want.serial_high);
            if (got.serial_low !== want.serial_low)
                flag_mismatch("serial_low", got.serial_low, want.serial_low);
            if (got.work_status !== want.work_status)
                flag_mismatch("work_status", got.work_status, want.work_status);
            if (got.alarm_bits !== want.alarm_bits)
                flag_mismatch("alarm_bits", got.alarm_bits, want.alarm_bits);
            if (got.temperature !== want.temperature)
                flag_mismatch("temperature", got.temperature, want.temperature);
            if (got.drive_current !== want.drive_current)
                flag_mismatch("drive_current", got.drive_current, want.drive_current);
            if (got.output_power !== want.output_power)
                flag_mismatch("output_power", got.output_power, want.output_power);
            if (got.set_power !== want.set_power)
                flag_mismatch("set_power", got.set_power, want.set_power);
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        t_rx_slot s;
        s.data    = b;
        s.drain   = 1'b0;
        s.squeeze = gen_squeeze;
        s.quiet   = gen_quiet;
        rx_pending.push_back(s);
        gen_squeeze = 1'b0;
        rx_items++;
    endtask

    task automatic add_drain();
        t_rx_slot s;
        s.data    = '0;
        s.drain   = 1'b1;
        s.squeeze = 1'b0;
        s.quiet   = gen_quiet;
        rx_pending.push_back(s);
    endtask

    task automatic add_frame(input logic [7:0] cmd, input int len);
        add_byte(lsfp_pkg::SYNC_FIRST);
        add_byte(lsfp_pkg::SYNC_SECOND);
        add_byte(cmd);
        add_byte(len[7:0]);
        for (int i = 0; i < len; i++) begin
            if (cmd == lsfp_pkg::CMD_LASER_ON && i == 0 && $urandom_range(0, 1) == 0)
                add_byte(8'd1);
            else add_byte(8'($urandom_range(0, 255)));
        end
        add_byte(8'($urandom_range(0, 255)));
        add_byte(8'($urandom_range(0, 255)));
    endtask

    // sender: offers pending bytes, predicts on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
            stall_go      <= 1'b0;
            rx_calm       <= 1'b0;
            phase         = HUNT_FIRST;
            frame_cmd     = '0;
            frame_len     = '0;
            data_count    = '0;
            foreach (capture[i]) capture[i] = '0;
            send_gap      = 0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                parse_rx_byte(rx_ch.rx_byte);
                stall_go <= rx_pending[0].squeeze;
                void'(rx_pending.pop_front());
            end else begin
                stall_go <= 1'b0;
            end
            if (rx_pending.size() > 0) rx_calm <= rx_pending[0].quiet;
            if (rx_ch.valid && !rx_ch.ready) begin
                // hold the offered byte until transfer
            end else if (send_gap > 0) begin
                send_gap--;
                rx_ch.valid <= 1'b0;
            end else if (rx_pending.size() == 0) begin
                rx_ch.valid <= 1'b0;
            end else if (rx_pending[0].drain) begin
                rx_ch.valid <= 1'b0;
                if (frames_expected.size() == 0) void'(rx_pending.pop_front());
            end else if (!rx_pending[0].quiet && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 9);
                rx_ch.valid <= 1'b0;
            end else begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= rx_pending[0].data;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) hold_cnt <= 0;
        else if (stall_go) hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end

    // receiver: checks each result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_gap     = 0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                check_frame('{lsfp_pkg::t_kind'(res_ch.frame_kind), res_ch.laser_on,
                              res_ch.serial_high, res_ch.serial_low, res_ch.work_status,
                              res_ch.alarm_bits, res_ch.temperature, res_ch.drive_current,
                              res_ch.output_power, res_ch.set_power});
            if (hold_cnt > 0) begin
                res_ch.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_ch.ready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 9);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int  pick;
        int  len;
        logic [7:0] cmd;
        bit  squeezed;
        bit  paused;
        bit  huge_done;

        i_rst_n       = 1'b0;
        rx_items      = 0;
        gen_quiet     = 1'b0;
        gen_squeeze   = 1'b0;
        squeezed      = 1'b0;
        paused        = 1'b0;
        huge_done     = 1'b0;

        // lone first sync byte, then repeated sync and an empty laser-on frame
        add_byte(8'hFF); add_byte(lsfp_pkg::SYNC_FIRST); add_byte(8'h00);
        add_byte(lsfp_pkg::SYNC_FIRST); add_byte(lsfp_pkg::SYNC_FIRST);
        add_byte(lsfp_pkg::SYNC_SECOND);
        add_byte(lsfp_pkg::CMD_LASER_ON); add_byte(8'h00); add_byte(8'hFF); add_byte(8'h00);
        // ignored command
        add_byte(lsfp_pkg::SYNC_FIRST); add_byte(lsfp_pkg::SYNC_SECOND);
        add_byte(lsfp_pkg::CMD_IGNORED);
        add_byte(8'h01); add_byte(8'hFF); add_byte(8'h12); add_byte(8'h34);
        // short status frame
        add_byte(lsfp_pkg::SYNC_FIRST); add_byte(lsfp_pkg::SYNC_SECOND);
        add_byte(lsfp_pkg::CMD_STATUS);
        add_byte(8'h02); add_byte(8'hFF); add_byte(8'h80); add_byte(8'h00); add_byte(8'h00);

        while (rx_items < RX_TARGET) begin
            if (rx_items > RX_TARGET * 85 / 100) gen_quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (!squeezed && rx_items > 250) begin
                squeezed    = 1'b1;
                gen_squeeze = 1'b1;
                repeat (14) add_frame(lsfp_pkg::CMD_LASER_ON, $urandom_range(0, 1));
                add_drain();
            end else if (!huge_done && rx_items > 350) begin
                huge_done = 1'b1;
                add_frame(($urandom_range(0, 1) == 0) ? lsfp_pkg::CMD_IDENTITY
                                                      : lsfp_pkg::CMD_STATUS, 255);
            end else if (!paused && rx_items > 650) begin
                paused = 1'b1;
                add_drain();
            end else if (pick < 8) begin
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
            end else if (pick < 12) begin
                add_byte(lsfp_pkg::SYNC_FIRST);
                add_byte(8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 9))
                    0, 1:    cmd = lsfp_pkg::CMD_LASER_ON;
                    2, 3, 4: cmd = lsfp_pkg::CMD_IDENTITY;
                    5, 6, 7: cmd = lsfp_pkg::CMD_STATUS;
                    8:       cmd = lsfp_pkg::CMD_IGNORED;
                    default: cmd = 8'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 15) == 0) len = $urandom_range(18, 40);
                else if (cmd == lsfp_pkg::CMD_LASER_ON) len = $urandom_range(0, 3);
                else if (cmd == lsfp_pkg::CMD_IDENTITY)
                    len = ($urandom_range(0, 2) != 0) ? 17 : $urandom_range(0, 24);
                else if (cmd == lsfp_pkg::CMD_STATUS) len = $urandom_range(0, 14);
                else len = $urandom_range(0, 20);
                add_frame(cmd, len);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_pending.size() > 0 || frames_expected.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* laser_status_frame_parser_unit.f */
hw/rtl/lsfp_pkg.sv
hw/rtl/lsfp_if.sv
hw/rtl/lsfp_front.sv
hw/rtl/lsfp_queue.sv
hw/rtl/lsfp_back.sv
hw/rtl/laser_status_frame_parser_unit.sv
sim/laser_status_frame_parser_unit_tb.sv
